// File: design/mrc_pkg.sv
// ----------------------------------------------------------------------------
// mrc_pkg
// Shared types, constants and the CRC-16 byte update for the response checker.
// ----------------------------------------------------------------------------
package mrc_pkg;

	localparam int unsigned MAX_FRAME_BYTES_DEF = 256;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 8;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [7:0] SLAVE_RST = 8'd1;
	localparam logic [7:0] FUNC_RST = 8'd3;
	localparam logic [6:0] COUNT_RST = 7'd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SLAVE = 2'd0,
		REG_FUNCTION = 2'd1,
		REG_QUANTITY = 2'd2
	} mrc_reg_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_SHORT = 3'd1,
		ST_SLAVE = 3'd2,
		ST_FUNC = 3'd3,
		ST_COUNT = 3'd4,
		ST_CRC = 3'd5
	} mrc_status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic frame_end;
	} mrc_in_t;

	typedef struct packed {
		logic is_status;
		logic [7:0] payload_byte;
		logic [7:0] payload_index;
		logic [2:0] frame_status;
		logic [15:0] computed_crc;
	} mrc_out_t;

	typedef struct packed {
		logic [7:0] expected_slave;
		logic [7:0] expected_function;
		logic [6:0] register_count;
	} mrc_cfg_t;

	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// File: design/mrc_cfg_regs.sv
// ----------------------------------------------------------------------------
// mrc_cfg_regs
// Configuration register file; writes to unknown indices are dropped.
// ----------------------------------------------------------------------------
module mrc_cfg_regs (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [mrc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mrc_pkg::CFG_DATA_W-1:0] cfg_data,
	output mrc_pkg::mrc_cfg_t cfg
);
	import mrc_pkg::*;

	mrc_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_slave <= SLAVE_RST;
			cfg_q.expected_function <= FUNC_RST;
			cfg_q.register_count <= COUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SLAVE: cfg_q.expected_slave <= cfg_data;
				REG_FUNCTION: cfg_q.expected_function <= cfg_data;
				REG_QUANTITY: cfg_q.register_count <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: design/mrc_frame_check.sv
// ----------------------------------------------------------------------------
// mrc_frame_check
// Per-frame state, header checks, lagged CRC and result formation.
// ----------------------------------------------------------------------------
module mrc_frame_check #(
	parameter int unsigned MAX_FRAME_BYTES = mrc_pkg::MAX_FRAME_BYTES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  mrc_pkg::mrc_in_t item,
	input  mrc_pkg::mrc_cfg_t cfg,
	output logic res_valid,
	output mrc_pkg::mrc_out_t res
);
	import mrc_pkg::*;

	localparam int unsigned POS_W = $clog2(MAX_FRAME_BYTES + 1);
	localparam int unsigned EXT_W = 10;
	localparam logic [EXT_W-1:0] POS_MAX = EXT_W'(MAX_FRAME_BYTES);

	logic [POS_W-1:0] pos_q;
	logic [15:0] crc_q;
	logic [7:0] held0_q;
	logic [7:0] held1_q;
	mrc_status_t err_q;

	logic [EXT_W-1:0] p;
	logic [7:0] plen;
	logic [EXT_W-1:0] plen_x;
	mrc_status_t err_nxt;
	mrc_status_t status;
	logic [15:0] crc_nxt;
	logic [EXT_W-1:0] idx;
	logic is_payload;

	always_comb begin
		p = {{(EXT_W-POS_W){1'b0}}, pos_q};
		plen = {cfg.register_count, 1'b0};
		plen_x = {{(EXT_W-8){1'b0}}, plen};

		err_nxt = err_q;
		if (err_q == ST_OK) begin
			if (p == EXT_W'(0) && item.data_byte != cfg.expected_slave) begin
				err_nxt = ST_SLAVE;
			end else if (p == EXT_W'(1) && item.data_byte != cfg.expected_function) begin
				err_nxt = ST_FUNC;
			end else if (p == EXT_W'(2) && item.data_byte != plen) begin
				err_nxt = ST_COUNT;
			end
		end

		crc_nxt = (p >= EXT_W'(2)) ? crc_feed(crc_q, held0_q) : crc_q;

		if (err_nxt != ST_OK) begin
			status = err_nxt;
		end else if (p < EXT_W'(2)) begin
			status = ST_SHORT;
		end else if (crc_nxt[7:0] != held1_q || crc_nxt[15:8] != item.data_byte) begin
			status = ST_CRC;
		end else if (p < EXT_W'(4) + plen_x) begin
			status = ST_SHORT;
		end else begin
			status = ST_OK;
		end

		idx = p - EXT_W'(3);
		is_payload = (p < POS_MAX) && (p >= EXT_W'(3)) && (p < EXT_W'(3) + plen_x);

		res = '0;
		if (item.frame_end) begin
			res_valid = 1'b1;
			res.is_status = 1'b1;
			res.frame_status = status;
			res.computed_crc = crc_nxt;
		end else begin
			res_valid = is_payload;
			res.payload_byte = item.data_byte;
			res.payload_index = idx[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			crc_q <= CRC_INIT;
			held0_q <= '0;
			held1_q <= '0;
			err_q <= ST_OK;
		end else if (step) begin
			if (item.frame_end) begin
				pos_q <= '0;
				crc_q <= CRC_INIT;
				held0_q <= '0;
				held1_q <= '0;
				err_q <= ST_OK;
			end else begin
				if (p < POS_MAX) begin
					pos_q <= pos_q + POS_W'(1);
				end
				crc_q <= crc_nxt;
				held0_q <= held1_q;
				held1_q <= item.data_byte;
				err_q <= err_nxt;
			end
		end
	end

endmodule

// File: design/modbus_rtu_response_checker.sv
// ----------------------------------------------------------------------------
// modbus_rtu_response_checker
// Modbus RTU read-response checker: header, byte count and CRC-16 checks,
// payload pass-through and one end-of-frame status transfer.
// ----------------------------------------------------------------------------
// Input transfers pass through the input register, then the result register.
// Throughput: one byte per cycle while the output is not stalled. Reset clears
// frame state and loads register defaults (slave 1, function 3, count 1); frame
// state also clears after each last byte.
module modbus_rtu_response_checker #(
	parameter int unsigned MAX_FRAME_BYTES = mrc_pkg::MAX_FRAME_BYTES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  mrc_pkg::mrc_in_t in_item,
	output logic out_valid,
	input  logic out_ready,
	output mrc_pkg::mrc_out_t out_item,
	input  logic cfg_we,
	input  logic [mrc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mrc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import mrc_pkg::*;

	mrc_cfg_t cfg;
	logic valid_s1;
	mrc_in_t item_s1;
	logic advance;
	logic res_valid;
	mrc_out_t res;
	logic out_valid_q;
	mrc_out_t out_item_q;

	mrc_cfg_regs u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	mrc_frame_check #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_check (
		.clk(clk),
		.arst_n(arst_n),
		.step(advance),
		.item(item_s1),
		.cfg(cfg),
		.res_valid(res_valid),
		.res(res)
	);

	assign advance = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_item_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_item_q;

endmodule

// File: dv/modbus_rtu_response_checker_test.sv
// ----------------------------------------------------------------------------
// modbus_rtu_response_checker_test
// Self-checking bench for the Modbus RTU read-response checker. Builds
// response frames (good, padded, corrupted, truncated, noise, overlong),
// drives them byte by byte under random sender bursts and receiver stalls,
// and predicts every payload and status transfer from a local copy of the
// frame state and register settings.
// ----------------------------------------------------------------------------
module modbus_rtu_response_checker_test;
	import mrc_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int ITEM_TARGET = 1000;
	localparam int IDLE_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 6;

	typedef enum {F_GOOD, F_LONG, F_SLAVE, F_FUNC, F_COUNT, F_CRC, F_TRUNC, F_NOISE} frame_kind_t;
	typedef enum {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_STARVED} rx_mode_t;

	class response_predictor;
		mrc_out_t due_results[$];
		int errors;
		int printed;
		logic [7:0] slave;
		logic [7:0] func;
		logic [6:0] count;
		int pos;
		logic [15:0] crc;
		logic [7:0] held_old;
		logic [7:0] held_new;
		mrc_status_t first_err;

		function new();
			errors = 0;
			printed = 0;
			slave = SLAVE_RST;
			func = FUNC_RST;
			count = COUNT_RST;
			clear_frame();
		endfunction

		function void clear_frame();
			pos = 0;
			crc = CRC_INIT;
			held_old = '0;
			held_new = '0;
			first_err = ST_OK;
		endfunction

		static function logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
			logic [15:0] r;
			r = c ^ {8'h00, b};
			repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
			return r;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] d);
			case (idx)
				REG_SLAVE: slave = d;
				REG_FUNCTION: func = d;
				REG_QUANTITY: count = d[6:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		function void take_byte(mrc_in_t it);
			int p;
			int plen;
			mrc_out_t r;
			mrc_status_t st;
			p = pos;
			plen = int'(count) * 2;
			r = '0;
			if (first_err == ST_OK) begin
				if (p == 0 && it.data_byte != slave) first_err = ST_SLAVE;
				else if (p == 1 && it.data_byte != func) first_err = ST_FUNC;
				else if (p == 2 && it.data_byte != 8'(plen)) first_err = ST_COUNT;
			end
			// CRC trails the input by two bytes
			if (p >= 2) crc = crc_byte(crc, held_old);
			if (it.frame_end) begin
				if (first_err != ST_OK) st = first_err;
				else if (p < 2) st = ST_SHORT;
				else if (crc[7:0] != held_new || crc[15:8] != it.data_byte) st = ST_CRC;
				else if (p < 4 + plen) st = ST_SHORT;
				else st = ST_OK;
				r.is_status = 1'b1;
				r.frame_status = st;
				r.computed_crc = crc;
				due_results.push_back(r);
				clear_frame();
				return;
			end
			held_old = held_new;
			held_new = it.data_byte;
			if (p < MAX_FRAME_BYTES_DEF) pos = p + 1;
			if (p < MAX_FRAME_BYTES_DEF && p >= 3 && p < 3 + plen) begin
				r.payload_byte = it.data_byte;
				r.payload_index = 8'(p - 3);
				due_results.push_back(r);
			end
		endfunction

		task report(string msg);
			errors++;
			if (printed < 40) begin
				$display("mismatch at %0t: %s", $realtime, msg);
				printed++;
			end
		endtask

		task match_result(mrc_out_t got);
			mrc_out_t w;
			if (due_results.size() == 0) begin
				report($sformatf("result with nothing due: status %0d byte %h",
					got.is_status, got.payload_byte));
				return;
			end
			w = due_results.pop_front();
			if (got.is_status !== w.is_status)
				report($sformatf("is_status %b, want %b", got.is_status, w.is_status));
			if (got.payload_byte !== w.payload_byte)
				report($sformatf("payload_byte %h, want %h", got.payload_byte, w.payload_byte));
			if (got.payload_index !== w.payload_index)
				report($sformatf("payload_index %0d, want %0d", got.payload_index,
					w.payload_index));
			if (got.frame_status !== w.frame_status)
				report($sformatf("frame_status %0d, want %0d", got.frame_status, w.frame_status));
			if (got.computed_crc !== w.computed_crc)
				report($sformatf("computed_crc %h, want %h", got.computed_crc, w.computed_crc));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	mrc_in_t in_item;
	logic out_valid;
	logic out_ready;
	mrc_out_t out_item;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	response_predictor pred;
	logic [7:0] frame_bytes[$];
	int burst_left = 0;
	int items_sent = 0;
	int idle_cycles = 0;
	int rx_tick = 0;
	rx_mode_t rx_mode = RX_OPEN;

	modbus_rtu_response_checker dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (rx_tick == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_tick = $urandom_range(20, 120);
		end
		rx_tick--;
		case (rx_mode)
			RX_OPEN: out_ready <= 1'b1;
			RX_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
			RX_PERIODIC: out_ready <= (rx_tick % 5 < 2);
			default: out_ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) pred.take_byte(in_item);
			if (out_valid && out_ready) pred.match_result(out_item);
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic is_last);
		mrc_in_t it;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
				: $urandom_range(1, 16);
		end
		it.data_byte = b;
		it.frame_end = is_last;
		in_item <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		burst_left--;
		items_sent++;
	endtask

	// hold off until every due result has transferred and the pipe is empty
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pred.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input logic [7:0] slave_v, func_v, count_v);
		logic [CFG_IDX_W-1:0] idx [4];
		logic [7:0] val [4];
		int k;
		idx = '{REG_SLAVE, REG_FUNCTION, REG_QUANTITY, REG_SPARE};
		val = '{slave_v, func_v, count_v, 8'($urandom)};
		for (k = 0; k < 4; k++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[k];
			cfg_data <= val[k];
			@(posedge clk);
			pred.set_reg(idx[k], val[k]);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic configure_random();
		configure(8'($urandom), 8'($urandom), ($urandom_range(0, 15) == 0) ? 8'($urandom)
			: {1'($urandom), 7'($urandom_range(0, 6))});
	endtask

	function automatic void build_frame(frame_kind_t kind, int extra);
		logic [15:0] c;
		int n_pay;
		int cut;
		frame_bytes.delete();
		n_pay = int'(pred.count) * 2;
		frame_bytes.push_back(pred.slave);
		frame_bytes.push_back(pred.func);
		frame_bytes.push_back(8'(n_pay));
		repeat (n_pay) frame_bytes.push_back(8'($urandom));
		if (kind == F_LONG) repeat (extra) frame_bytes.push_back(8'($urandom));
		c = CRC_INIT;
		foreach (frame_bytes[i]) c = response_predictor::crc_byte(c, frame_bytes[i]);
		frame_bytes.push_back(c[7:0]);
		frame_bytes.push_back(c[15:8]);
		case (kind)
			F_SLAVE: frame_bytes[0] ^= 8'($urandom_range(1, 255));
			F_FUNC: frame_bytes[1] ^= 8'($urandom_range(1, 255));
			F_COUNT: frame_bytes[2] ^= 8'($urandom_range(1, 255));
			F_CRC: frame_bytes[frame_bytes.size() - 1 - $urandom_range(0, 1)]
				^= 8'($urandom_range(1, 255));
			F_TRUNC: begin
				cut = $urandom_range(1, frame_bytes.size() - 1);
				while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
			end
			F_NOISE: begin
				frame_bytes.delete();
				repeat ($urandom_range(1, 10)) frame_bytes.push_back(8'($urandom));
			end
			default: ;
		endcase
	endfunction

	// split >= 0 rewrites the registers before that byte, mid-frame
	task automatic send_frame(input int split);
		int i;
		for (i = 0; i < frame_bytes.size(); i++) begin
			if (i == split) begin
				drain();
				configure_random();
			end
			send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
		end
	endtask

	initial begin
		int kind_pick;
		int split;
		frame_kind_t kind;
		pred = new();
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_item <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: good frame, tiny frames, bad CRC, end inside payload, mid-frame rewrite
		build_frame(F_GOOD, 0);
		send_frame(-1);
		frame_bytes = '{SLAVE_RST};
		send_frame(-1);
		frame_bytes = '{8'h00};
		send_frame(-1);
		frame_bytes = '{SLAVE_RST, 8'hFF};
		send_frame(-1);
		build_frame(F_CRC, 0);
		send_frame(-1);
		frame_bytes = '{SLAVE_RST, FUNC_RST, 8'h02, 8'hFF};
		send_frame(-1);
		build_frame(F_GOOD, 0);
		send_frame(3);

		drain();
		configure(8'hFF, 8'h00, 8'h00);
		frame_bytes = '{8'hFF, 8'h00, 8'h02};
		send_frame(-1);
		build_frame(F_GOOD, 0);
		send_frame(-1);

		// count 125 with top data bit set, padded past position saturation
		drain();
		configure(8'h00, 8'hFF, 8'hFD);
		build_frame(F_LONG, 40);
		send_frame(-1);
		drain();
		configure(SLAVE_RST, FUNC_RST, 8'h01);

		while (items_sent < ITEM_TARGET) begin
			if ($urandom_range(0, 9) == 0) begin
				drain();
				configure_random();
			end
			kind_pick = $urandom_range(0, 15);
			if (kind_pick < 7) kind = F_GOOD;
			else if (kind_pick < 9) kind = F_LONG;
			else if (kind_pick == 15) kind = F_TRUNC;
			else kind = frame_kind_t'(kind_pick - 7);
			build_frame(kind, $urandom_range(1, 6));
			split = -1;
			if (frame_bytes.size() > 1 && $urandom_range(0, 15) == 0)
				split = $urandom_range(1, frame_bytes.size() - 1);
			send_frame(split);
		end

		drain();
		if (pred.errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
